FILE: sv/range_sweep_object_finder_core_assert.svh
// Assertion macros used by the range sweep object finder checker.
`ifndef RANGE_SWEEP_OBJECT_FINDER_CORE_ASSERT_SVH
`define RANGE_SWEEP_OBJECT_FINDER_CORE_ASSERT_SVH

// Same-cycle implication.
`define RSOF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("range sweep object finder check failed");

// Next-cycle implication.
`define RSOF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("range sweep object finder check failed");

`endif

FILE: sv/rsof_pkg.sv
// Package: types, register map and reset values of the range sweep object finder.
package rsof_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [1:0] REG_CLAMP_LIMIT    = 2'd0;
    localparam logic [1:0] REG_JUMP_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_MIN_WIDTH      = 2'd2;
    localparam logic [1:0] REG_MAX_OBJECTS    = 2'd3;

    localparam logic [15:0] CLAMP_LIMIT_RST    = 16'd1600;
    localparam logic [15:0] JUMP_THRESHOLD_RST = 16'd160;
    localparam logic [7:0]  MIN_WIDTH_RST      = 8'd3;
    localparam logic [7:0]  MAX_OBJECTS_RST    = 8'd20;

    typedef struct packed {
        logic [15:0] clamp_limit;
        logic [15:0] jump_threshold;
        logic [7:0]  min_width;
        logic [7:0]  max_objects;
    } cfg_t;

    typedef struct packed {
        logic        sweep_start;
        logic [7:0]  angle_deg;
        logic [15:0] range_value;
    } item_t;

    typedef struct packed {
        logic [15:0] clamped_range;
        logic [7:0]  object_count;
        logic        object_closed;
        logic [7:0]  closed_width;
        logic [7:0]  closed_center;
        logic        best_valid;
        logic [7:0]  best_center;
        logic        list_full;
    } result_t;

endpackage

FILE: sv/rsof_cfg.sv
// Configuration register file with APB-style access.
module rsof_cfg
    import rsof_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output cfg_t                cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clamp_limit    <= CLAMP_LIMIT_RST;
            cfg_reg.jump_threshold <= JUMP_THRESHOLD_RST;
            cfg_reg.min_width      <= MIN_WIDTH_RST;
            cfg_reg.max_objects    <= MAX_OBJECTS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CLAMP_LIMIT:    cfg_reg.clamp_limit    <= pwdata[15:0];
                REG_JUMP_THRESHOLD: cfg_reg.jump_threshold <= pwdata[15:0];
                REG_MIN_WIDTH:      cfg_reg.min_width      <= pwdata[7:0];
                REG_MAX_OBJECTS:    cfg_reg.max_objects    <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CLAMP_LIMIT:    prdata = {16'd0, cfg_reg.clamp_limit};
            REG_JUMP_THRESHOLD: prdata = {16'd0, cfg_reg.jump_threshold};
            REG_MIN_WIDTH:      prdata = {24'd0, cfg_reg.min_width};
            REG_MAX_OBJECTS:    prdata = {24'd0, cfg_reg.max_objects};
            default:            prdata = '0;
        endcase
    end

endmodule

FILE: sv/rsof_track.sv
// Sweep state and per-sample edge, object and best-object logic.
module rsof_track
    import rsof_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [15:0] prev_range_reg, prev_range_eff;
    logic        prev_valid_reg, prev_valid_eff;
    logic        open_reg, open_eff, open_next;
    logic [7:0]  start_reg, start_eff, start_next;
    logic [7:0]  total_reg, total_eff, total_next;
    logic [7:0]  bwidth_reg, bwidth_eff, bwidth_next;
    logic [7:0]  bangle_reg, bangle_eff, bangle_next;
    logic        found_reg, found_eff, found_next;

    logic [15:0] clamped;
    logic [15:0] diff;
    logic        edge_hit;
    logic        act;
    logic        closing;
    logic [7:0]  cw;
    logic [8:0]  csum;
    logic [7:0]  cc;
    logic        take_best;

    always_comb
    begin
        prev_range_eff = item.sweep_start ? 16'd0 : prev_range_reg;
        prev_valid_eff = item.sweep_start ? 1'b0  : prev_valid_reg;
        open_eff       = item.sweep_start ? 1'b0  : open_reg;
        start_eff      = item.sweep_start ? 8'd0  : start_reg;
        total_eff      = item.sweep_start ? 8'd0  : total_reg;
        bwidth_eff     = item.sweep_start ? 8'd0  : bwidth_reg;
        bangle_eff     = item.sweep_start ? 8'd0  : bangle_reg;
        found_eff      = item.sweep_start ? 1'b0  : found_reg;

        clamped  = (item.range_value < cfg.clamp_limit) ? item.range_value : cfg.clamp_limit;
        diff     = (clamped >= prev_range_eff) ? clamped - prev_range_eff
                                               : prev_range_eff - clamped;
        edge_hit = prev_valid_eff && (diff >= cfg.jump_threshold);
        act      = edge_hit && (total_eff < cfg.max_objects);
        closing  = act && open_eff;

        cw   = item.angle_deg - start_eff;
        csum = {1'b0, item.angle_deg} + {1'b0, start_eff};
        cc   = csum[8:1];

        take_best = closing && (cw > cfg.min_width) && (!found_eff || cw <= bwidth_eff);

        open_next   = act ? !open_eff : open_eff;
        start_next  = (act && !open_eff) ? item.angle_deg : start_eff;
        total_next  = closing ? total_eff + 8'd1 : total_eff;
        found_next  = found_eff | take_best;
        bwidth_next = take_best ? cw : bwidth_eff;
        bangle_next = take_best ? cc : bangle_eff;

        result.clamped_range = clamped;
        result.object_count  = total_next;
        result.object_closed = closing;
        result.closed_width  = closing ? cw : 8'd0;
        result.closed_center = closing ? cc : 8'd0;
        result.best_valid    = found_next;
        result.best_center   = found_next ? bangle_next : 8'd0;
        result.list_full     = total_next >= cfg.max_objects;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_range_reg <= '0;
            prev_valid_reg <= 1'b0;
            open_reg       <= 1'b0;
            start_reg      <= '0;
            total_reg      <= '0;
            bwidth_reg     <= '0;
            bangle_reg     <= '0;
            found_reg      <= 1'b0;
        end
        else if (fire)
        begin
            prev_range_reg <= clamped;
            prev_valid_reg <= 1'b1;
            open_reg       <= open_next;
            start_reg      <= start_next;
            total_reg      <= total_next;
            bwidth_reg     <= bwidth_next;
            bangle_reg     <= bangle_next;
            found_reg      <= found_next;
        end
    end

endmodule

FILE: sv/range_sweep_object_finder_core.sv
// Top level of the range sweep object finder.
// Usage:
//   Sample channel (sample_valid/sample_ready) carries one range sample per
//   beat: sweep_start, angle_deg, range_value. Set sweep_start on the first
//   sample of each sweep to clear the object and best-object state.
//   Result channel (result_valid/result_ready) returns one beat per sample,
//   in order, with the clamped range, object count, closed-object data,
//   the narrowest qualifying object and the list-full flag.
//   Result path: the sample passes the input register, then the result
//   register. Throughput: one sample per cycle while the receiver does not stall,
//   with the sweep state updated as each sample moves between the two registers.
//   Receiver stall: the result register holds; the input register takes
//   one more beat, after which sample_ready drops until result_ready returns.
//   Reset: both registers empty, sweep state cleared, configuration
//   registers at their defaults. Write configuration only while idle.
module range_sweep_object_finder_core
    import rsof_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  logic                sweep_start,
    input  logic [7:0]          angle_deg,
    input  logic [15:0]         range_value,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [15:0]         clamped_range,
    output logic [7:0]          object_count,
    output logic                object_closed,
    output logic [7:0]          closed_width,
    output logic [7:0]          closed_center,
    output logic                best_valid,
    output logic [7:0]          best_center,
    output logic                list_full
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;
    logic    fire;

    assign pready = 1'b1;

    rsof_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign advance      = !res_valid_reg || result_ready;
    assign fire         = item_valid_reg && advance;
    assign sample_ready = !item_valid_reg || advance;

    rsof_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                item_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                res_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            item_reg.sweep_start <= sweep_start;
            item_reg.angle_deg   <= angle_deg;
            item_reg.range_value <= range_value;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign result_valid  = res_valid_reg;
    assign clamped_range = res_reg.clamped_range;
    assign object_count  = res_reg.object_count;
    assign object_closed = res_reg.object_closed;
    assign closed_width  = res_reg.closed_width;
    assign closed_center = res_reg.closed_center;
    assign best_valid    = res_reg.best_valid;
    assign best_center   = res_reg.best_center;
    assign list_full     = res_reg.list_full;

endmodule

FILE: sv/rsof_checker.sv
// Port-level checker for the range sweep object finder, bound to the top level.
`include "range_sweep_object_finder_core_assert.svh"

module rsof_checker
    import rsof_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                pready,
    input logic                result_valid,
    input logic                result_ready,
    input logic [15:0]         clamped_range,
    input logic [7:0]          object_count,
    input logic                object_closed,
    input logic [7:0]          closed_width,
    input logic [7:0]          closed_center,
    input logic                best_valid,
    input logic [7:0]          best_center
);

    `RSOF_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(clamped_range) && $stable(object_count))
    `RSOF_ASSERT_NOW(a_open_zero, clk, rst_n, result_valid && !object_closed, closed_width == 8'd0 && closed_center == 8'd0)
    `RSOF_ASSERT_NOW(a_best_zero, clk, rst_n, result_valid && !best_valid, best_center == 8'd0)
    `RSOF_ASSERT_NOW(a_close_counts, clk, rst_n, result_valid && object_closed, object_count != 8'd0 && pready)

endmodule

bind range_sweep_object_finder_core rsof_checker u_rsof_checker (.*);
